@@ rtl/lagged_pair_nearest_match_core_macros.svh @@
// ----------------------------------------------------------------------------
// lagged_pair_nearest_match_core_macros
// assertion shorthands for the core rtl file
// ----------------------------------------------------------------------------
`ifndef LAGGED_PAIR_NEAREST_MATCH_CORE_MACROS_SVH
`define LAGGED_PAIR_NEAREST_MATCH_CORE_MACROS_SVH

// property on an explicit clock and active-low reset
`define LPNM_ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// property on the house clock and reset
`define LPNM_ASSERT(lbl, prop, msg) \
  `LPNM_ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/lpnm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpnm_pkg
// types and constants of the lagged pair nearest match core
// ----------------------------------------------------------------------------
package lpnm_pkg;

  localparam int unsigned COORDS        = 4;
  localparam int unsigned COORD_BITS    = 16;
  localparam int unsigned DIST_BITS     = 34;
  localparam int unsigned SCORE_BITS    = 35;
  localparam int unsigned INDEX_BITS    = 16;
  localparam int unsigned LAG_BITS      = 8;
  localparam int unsigned DIMS_BITS     = 3;
  localparam int unsigned REQ_BITS      = 2;
  localparam int unsigned CFG_IDX_BITS  = 2;
  localparam int unsigned CFG_DATA_BITS = 8;
  localparam int unsigned IN_DATA_BITS  = COORDS * COORD_BITS;
  localparam int unsigned OUT_DATA_BITS = 56;
  localparam int unsigned OUT_PAD_BITS  = OUT_DATA_BITS - SCORE_BITS - INDEX_BITS;
  localparam int unsigned OUT_USER_BITS = 2;

  localparam logic [DIST_BITS-1:0]  DIST_MAX   = '1;
  localparam logic [SCORE_BITS-1:0] SCORE_MAX  = '1;
  localparam logic [LAG_BITS-1:0]   LAG_RESET  = 8'd1;
  localparam logic [DIMS_BITS-1:0]  DIMS_RESET = 3'd4;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef coord_t [COORDS-1:0] point_t;

  typedef enum logic [REQ_BITS-1:0] {
    REQ_REF_A = 2'd0,
    REQ_REF_B = 2'd1,
    REQ_ROW   = 2'd2
  } req_e;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_LAG  = 2'd0,
    CFG_DIMS = 2'd1
  } cfg_reg_e;

endpackage

@@ rtl/lagged_pair_nearest_match_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lagged_pair_nearest_match_core
// argmin over start rows of the summed squared distances of a lagged pair
// ----------------------------------------------------------------------------
// Takes one request per cycle: a reference load (tuser 0 or 1) or a
// trajectory row (tuser 2). Each row passes an input register, a distance
// stage (two banks of parallel squarers) and a scoring stage that reads the
// first distance of the row lag rows back from a MAX_LAG deep delay memory,
// then updates the running minimum. The row marked tlast produces one result,
// registered after the scoring stage; the input only stalls when a second
// closing row reaches the scoring stage while the previous result is still
// waiting on the output. Ties keep the earliest row; lag is clamped to
// MAX_LAG - 1; rows at index MAX_ROWS and above are dropped and reported.
module lagged_pair_nearest_match_core #(
  parameter int unsigned MAX_LAG  = 256,
  parameter int unsigned MAX_ROWS = 65536
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // coord_0, coord_1, coord_2, coord_3
  input  logic [lpnm_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
  // req_type
  input  logic [lpnm_pkg::REQ_BITS-1:0]        s_axis_tuser,
  input  logic                                 s_axis_tlast,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // best_index, best_score, zero pad
  output logic [lpnm_pkg::OUT_DATA_BITS-1:0]   m_axis_tdata,
  // found, row_overflow
  output logic [lpnm_pkg::OUT_USER_BITS-1:0]   m_axis_tuser,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [lpnm_pkg::CFG_IDX_BITS-1:0]    cfg_index_i,
  input  logic [lpnm_pkg::CFG_DATA_BITS-1:0]   cfg_data_i
);
  import lpnm_pkg::*;

  `include "lagged_pair_nearest_match_core_macros.svh"

  localparam int unsigned AW = (MAX_LAG > 1) ? $clog2(MAX_LAG) : 1;
  localparam int unsigned CW = $clog2(MAX_ROWS + 1);
  localparam int unsigned PW = ((AW > LAG_BITS) ? AW : LAG_BITS) + 1;
  localparam logic [LAG_BITS-1:0] LAG_CAP =
    ((MAX_LAG - 1) >= (1 << LAG_BITS)) ? '1 : LAG_BITS'(MAX_LAG - 1);
  localparam logic [CW-1:0] ROW_LIMIT = CW'(MAX_ROWS);
  localparam logic [AW-1:0] SLOT_LAST = AW'(MAX_LAG - 1);

  // configuration
  logic [LAG_BITS-1:0]  lag_q;
  logic [DIMS_BITS-1:0] dims_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lag_q  <= LAG_RESET;
      dims_q <= DIMS_RESET;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_LAG:  lag_q  <= cfg_data_i[LAG_BITS-1:0];
        CFG_DIMS: dims_q <= cfg_data_i[DIMS_BITS-1:0];
        default: ;
      endcase
    end
  end

  // input side
  logic   in_acc;
  logic   row_acc;
  req_e   in_req;
  point_t in_point;
  logic   adv1;
  logic   adv2;
  logic   s1_v_q;

  assign s_axis_tready = !s1_v_q || adv1;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign in_req        = req_e'(s_axis_tuser);
  assign in_point      = point_t'(s_axis_tdata);
  assign row_acc       = in_acc && (in_req == REQ_ROW);

  point_t ref_a_q;
  point_t ref_b_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ref_a_q <= '0;
      ref_b_q <= '0;
    end else if (in_acc) begin
      case (in_req)
        REQ_REF_A: ref_a_q <= in_point;
        REQ_REF_B: ref_b_q <= in_point;
        default: ;
      endcase
    end
  end

  // row counter and delay slot pointer
  logic [CW-1:0] row_cnt_q;
  logic [AW-1:0] wp_q;
  logic          cnt_full;

  assign cnt_full = (row_cnt_q == ROW_LIMIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_cnt_q <= '0;
      wp_q      <= '0;
    end else if (row_acc) begin
      if (s_axis_tlast) begin
        row_cnt_q <= '0;
        wp_q      <= '0;
      end else if (!cnt_full) begin
        row_cnt_q <= row_cnt_q + 1'b1;
        wp_q      <= (wp_q == SLOT_LAST) ? '0 : wp_q + 1'b1;
      end
    end
  end

  // stage 1: registered row
  point_t        s1_point_q;
  logic [CW-1:0] s1_cnt_q;
  logic [AW-1:0] s1_wp_q;
  logic          s1_ovf_q;
  logic          s1_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s_axis_tready) begin
      s1_v_q <= row_acc;
    end
  end

  always_ff @(posedge clk_i) begin
    if (row_acc) begin
      s1_point_q <= in_point;
      s1_cnt_q   <= row_cnt_q;
      s1_wp_q    <= wp_q;
      s1_ovf_q   <= cnt_full;
      s1_last_q  <= s_axis_tlast;
    end
  end

  logic [LAG_BITS-1:0]   eff_lag;
  logic                  s1_pair;
  logic [INDEX_BITS-1:0] s1_idx;
  logic [PW-1:0]         rdiff;
  logic [PW-1:0]         rwrap;
  logic [AW-1:0]         raddr;
  logic [DIST_BITS-1:0]  s1_d1;
  logic [DIST_BITS-1:0]  s1_d2;

  always_comb begin
    eff_lag = (lag_q > LAG_CAP) ? LAG_CAP : lag_q;
    s1_pair = (s1_cnt_q >= CW'(eff_lag));
    s1_idx  = INDEX_BITS'(s1_cnt_q - CW'(eff_lag));
    rdiff   = PW'(s1_wp_q) - PW'(eff_lag);
    rwrap   = rdiff + PW'(MAX_LAG);
    raddr   = rdiff[PW-1] ? rwrap[AW-1:0] : rdiff[AW-1:0];
  end

  lpnm_sqdist u_dist_a (
    .point_i (s1_point_q),
    .ref_i   (ref_a_q),
    .dims_i  (dims_q),
    .dist_o  (s1_d1)
  );

  lpnm_sqdist u_dist_b (
    .point_i (s1_point_q),
    .ref_i   (ref_b_q),
    .dims_i  (dims_q),
    .dist_o  (s1_d2)
  );

  // stage 2: scoring
  logic                  s2_v_q;
  logic [DIST_BITS-1:0]  s2_d1_q;
  logic [DIST_BITS-1:0]  s2_d2_q;
  logic                  s2_pair_q;
  logic                  s2_lag0_q;
  logic [INDEX_BITS-1:0] s2_idx_q;
  logic [AW-1:0]         s2_wp_q;
  logic                  s2_ovf_q;
  logic                  s2_last_q;
  logic [DIST_BITS-1:0]  rd_q;
  logic                  fwd_q;
  logic [DIST_BITS-1:0]  fwd_d_q;
  logic                  mem_we;
  logic [DIST_BITS-1:0]  dly_mem [MAX_LAG];

  assign adv2   = s2_v_q && !(s2_last_q && m_axis_tvalid && !m_axis_tready);
  assign adv1   = s1_v_q && (!s2_v_q || adv2);
  assign mem_we = adv2 && !s2_ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (!s2_v_q || adv2) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      s2_d1_q   <= s1_d1;
      s2_d2_q   <= s1_d2;
      s2_pair_q <= s1_pair;
      s2_lag0_q <= (eff_lag == '0);
      s2_idx_q  <= s1_idx;
      s2_wp_q   <= s1_wp_q;
      s2_ovf_q  <= s1_ovf_q;
      s2_last_q <= s1_last_q;
      // the row being written this cycle may be the one looked up
      fwd_q     <= mem_we && (s2_wp_q == raddr);
      fwd_d_q   <= s2_d1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      dly_mem[s2_wp_q] <= s2_d1_q;
    end
    if (adv1) begin
      rd_q <= dly_mem[raddr];
    end
  end

  logic [DIST_BITS-1:0]  prev;
  logic [SCORE_BITS:0]   sum;
  logic [SCORE_BITS-1:0] score;
  logic                  take;
  logic [SCORE_BITS-1:0] best_q;
  logic [INDEX_BITS-1:0] brow_q;
  logic                  have_q;
  logic                  ovf_seen_q;
  logic [SCORE_BITS-1:0] best_n;
  logic [INDEX_BITS-1:0] brow_n;
  logic                  have_n;
  logic                  ovf_n;

  always_comb begin
    prev   = s2_lag0_q ? s2_d1_q : (fwd_q ? fwd_d_q : rd_q);
    sum    = (SCORE_BITS + 1)'(prev) + (SCORE_BITS + 1)'(s2_d2_q);
    score  = sum[SCORE_BITS] ? SCORE_MAX : sum[SCORE_BITS-1:0];
    take   = s2_pair_q && !s2_ovf_q && (!have_q || (score < best_q));
    have_n = have_q || take;
    best_n = take ? score : best_q;
    brow_n = take ? s2_idx_q : brow_q;
    ovf_n  = ovf_seen_q || s2_ovf_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_q     <= '0;
      brow_q     <= '0;
      have_q     <= 1'b0;
      ovf_seen_q <= 1'b0;
    end else if (adv2) begin
      if (s2_last_q) begin
        best_q     <= '0;
        brow_q     <= '0;
        have_q     <= 1'b0;
        ovf_seen_q <= 1'b0;
      end else begin
        best_q     <= best_n;
        brow_q     <= brow_n;
        have_q     <= have_n;
        ovf_seen_q <= ovf_n;
      end
    end
  end

  // result register
  logic                  out_v_q;
  logic [INDEX_BITS-1:0] out_idx_q;
  logic [SCORE_BITS-1:0] out_score_q;
  logic                  out_found_q;
  logic                  out_ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (adv2 && s2_last_q) begin
      out_v_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && s2_last_q) begin
      out_idx_q   <= have_n ? brow_n : '0;
      out_score_q <= have_n ? best_n : '0;
      out_found_q <= have_n;
      out_ovf_q   <= ovf_n;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {{OUT_PAD_BITS{1'b0}}, out_score_q, out_idx_q};
  assign m_axis_tuser  = {out_ovf_q, out_found_q};

  `LPNM_ASSERT(a_no_pair_zero, m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata == '0, "result without pair carries data")
  `LPNM_ASSERT(a_cnt_bound, row_cnt_q <= ROW_LIMIT, "row counter past saturation")
  `LPNM_ASSERT(a_slot_bound, wp_q <= SLOT_LAST, "delay slot pointer out of range")
  `LPNM_ASSERT(a_search_restart, row_acc && s_axis_tlast |=> row_cnt_q == '0 && wp_q == '0, "search state not cleared after closing row")
  `LPNM_ASSERT(a_result_loaded, adv2 && s2_last_q |=> m_axis_tvalid, "closing row left no result")

endmodule

@@ rtl/lpnm_sqdist.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpnm_sqdist
// squared euclidean distance of a point to a reference over the first dims_i coordinates, parallel squarers
// ----------------------------------------------------------------------------
module lpnm_sqdist (
  input  lpnm_pkg::point_t                   point_i,
  input  lpnm_pkg::point_t                   ref_i,
  input  logic [lpnm_pkg::DIMS_BITS-1:0]     dims_i,
  output logic [lpnm_pkg::DIST_BITS-1:0]     dist_o
);
  import lpnm_pkg::*;

  localparam int unsigned DW    = COORD_BITS + 1;
  localparam int unsigned SW    = 2 * DW;
  localparam int unsigned ACC_W = SW + $clog2(COORDS) + 1;

  logic signed [DW-1:0] diff [COORDS];
  logic        [DW-1:0] mag  [COORDS];
  logic        [SW-1:0] sq   [COORDS];
  logic     [ACC_W-1:0] acc;

  always_comb begin
    acc = '0;
    for (int j = 0; j < COORDS; j++) begin
      diff[j] = DW'($signed(point_i[j])) - DW'($signed(ref_i[j]));
      mag[j]  = diff[j][DW-1] ? DW'(-diff[j]) : DW'(diff[j]);
      sq[j]   = (32'(j) < 32'(dims_i)) ? SW'(mag[j] * mag[j]) : '0;
      acc     = acc + ACC_W'(sq[j]);
    end
    dist_o = (acc > ACC_W'(DIST_MAX)) ? DIST_MAX : acc[DIST_BITS-1:0];
  end

endmodule
